// ===== rtl/sha512_hasher_unit_assert.svh =====
// ----------------------------------------------------------------------------
// SHA-512 hasher assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SHA512_HASHER_UNIT_ASSERT_SVH
`define SHA512_HASHER_UNIT_ASSERT_SVH

// same-cycle implication
`define SHA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-512 package
// Queue item type, initial hash value and round constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sha512_pkg;

   typedef struct packed {
      logic [63:0] word;
      logic        final_word;
   } queue_item_type;

   localparam logic [63:0] PAD_WORD = 64'h8000000000000000;

   localparam logic [63:0] INIT_HASH [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [63:0] ROUND_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

endpackage

`default_nettype wire

// ===== rtl/sha512_front.sv =====
// ----------------------------------------------------------------------------
// SHA-512 front end
// Accepts message items, counts bytes and emits block words with padding.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [63:0]                req_data_word,
   input  wire logic [3:0]                 req_valid_bytes,
   input  wire logic                       req_last_word,
   output logic                            push_valid,
   output sha512_pkg::queue_item_type      push_item,
   input  wire logic                       queue_full
);
   import sha512_pkg::*;

   typedef enum logic [2:0] {FR_IDLE, FR_PAD, FR_ZERO, FR_LEN_HI, FR_LEN_LO} state_type;

   state_type   state_ff, state_in;
   logic [3:0]  pos_ff, pos_in;
   logic [63:0] bytes_ff, bytes_in;
   logic [3:0]  vb_sat;
   logic [63:0] keep_mask;

   always_comb begin
      vb_sat    = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
      keep_mask = (vb_sat == 4'd0) ? 64'd0 : (~64'd0 << (7'd64 - {vb_sat, 3'b000}));
      state_in  = state_ff;
      pos_in    = pos_ff;
      bytes_in  = bytes_ff;
      req_stall = (state_ff != FR_IDLE) || queue_full;
      push_valid = 1'b0;
      push_item.word = 64'd0;
      push_item.final_word = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            if (req_valid && !queue_full) begin
               push_valid = 1'b1;
               pos_in = pos_ff + 4'd1;
               if (!req_last_word) begin
                  push_item.word = req_data_word;
                  bytes_in = bytes_ff + 64'd8;
               end else begin
                  bytes_in = bytes_ff + {60'd0, vb_sat};
                  if (vb_sat == 4'd8) begin
                     push_item.word = req_data_word;
                     state_in = FR_PAD;
                  end else begin
                     push_item.word = (req_data_word & keep_mask)
                                    | (PAD_WORD >> {vb_sat, 3'b000});
                     state_in = FR_ZERO;
                  end
               end
            end
         end
         FR_PAD: begin
            if (!queue_full) begin
               push_valid = 1'b1;
               push_item.word = PAD_WORD;
               pos_in = pos_ff + 4'd1;
               state_in = FR_ZERO;
            end
         end
         FR_ZERO: begin
            if (pos_ff == 4'd14) begin
               state_in = FR_LEN_HI;
            end else if (!queue_full) begin
               push_valid = 1'b1;
               pos_in = pos_ff + 4'd1;
            end
         end
         FR_LEN_HI: begin
            if (!queue_full) begin
               push_valid = 1'b1;
               push_item.word = {61'd0, bytes_ff[63:61]};
               pos_in = pos_ff + 4'd1;
               state_in = FR_LEN_LO;
            end
         end
         FR_LEN_LO: begin
            if (!queue_full) begin
               push_valid = 1'b1;
               push_item.word = {bytes_ff[60:0], 3'b000};
               push_item.final_word = 1'b1;
               pos_in = 4'd0;
               bytes_in = 64'd0;
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         pos_ff   <= 4'd0;
         bytes_ff <= 64'd0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         bytes_ff <= bytes_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sha512_queue.sv =====
// ----------------------------------------------------------------------------
// SHA-512 word queue
// Short FIFO of block words between the front end and the round engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire sha512_pkg::queue_item_type push_item,
   output logic                            full,
   input  wire logic                       pop,
   output sha512_pkg::queue_item_type      pop_item,
   output logic                            empty,
   output logic [$clog2(DEPTH+1)-1:0]      level
);
   import sha512_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   queue_item_type     slot_ff [DEPTH];
   logic [PW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               do_push, do_pop;

   always_comb begin
      full     = (cnt_ff == CW'(DEPTH));
      empty    = (cnt_ff == '0);
      level    = cnt_ff;
      pop_item = slot_ff[rd_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wr_in    = do_push ? ((wr_ff == PW'(DEPTH-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop ? ((rd_ff == PW'(DEPTH-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in   = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sha512_core.sv =====
// ----------------------------------------------------------------------------
// SHA-512 round engine
// Collects 16 words, runs 80 rounds, folds into the chain, emits the digest after a final block.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       queue_empty,
   input  wire sha512_pkg::queue_item_type queue_item,
   output logic                            queue_pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [63:0]                     rsp_digest_word,
   output logic [2:0]                      rsp_word_index,
   output logic                            rsp_digest_last
);
   import sha512_pkg::*;

   typedef enum logic [1:0] {ST_COLLECT, ST_ROUND, ST_ADD, ST_DIGEST} state_type;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   state_type   state_ff, state_in;
   logic [63:0] w_ff [16];
   logic [63:0] w_in [16];
   logic [63:0] v_ff [8];
   logic [63:0] v_in [8];
   logic [63:0] h_ff [8];
   logic [63:0] h_in [8];
   logic [3:0]  cnt_ff, cnt_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;
   logic        fin_ff, fin_in;
   logic [63:0] t1, t2, new_w;

   always_comb begin
      t1 = v_ff[7] + (rotr(v_ff[4], 14) ^ rotr(v_ff[4], 18) ^ rotr(v_ff[4], 41))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + ROUND_K[rnd_ff] + w_ff[0];
      t2 = (rotr(v_ff[0], 28) ^ rotr(v_ff[0], 34) ^ rotr(v_ff[0], 39))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      new_w = (rotr(w_ff[14], 19) ^ rotr(w_ff[14], 61) ^ (w_ff[14] >> 6)) + w_ff[9]
            + (rotr(w_ff[1], 1) ^ rotr(w_ff[1], 8) ^ (w_ff[1] >> 7)) + w_ff[0];

      state_in = state_ff;
      w_in     = w_ff;
      v_in     = v_ff;
      h_in     = h_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      fin_in   = fin_ff;
      queue_pop = 1'b0;

      unique case (state_ff)
         ST_COLLECT: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
               w_in[15] = queue_item.word;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  fin_in   = queue_item.final_word;
                  v_in     = h_ff;
                  rnd_in   = 7'd0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = new_w;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            rnd_in  = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
            idx_in   = 3'd0;
            state_in = fin_ff ? ST_DIGEST : ST_COLLECT;
         end
         ST_DIGEST: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  h_in     = INIT_HASH;
                  state_in = ST_COLLECT;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      rsp_valid       = (state_ff == ST_DIGEST);
      rsp_digest_word = h_ff[idx_ff];
      rsp_word_index  = idx_ff;
      rsp_digest_last = (idx_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      v_ff   <= v_in;
      rnd_ff <= rnd_in;
      fin_ff <= fin_in;
      if (reset) begin
         state_ff <= ST_COLLECT;
         h_ff     <= INIT_HASH;
         cnt_ff   <= 4'd0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         h_ff     <= h_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sha512_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-512 hasher unit
// Channel  Dir  Payload                                   Handshake
// req      in   data_word[63:0] valid_bytes[3:0] last     req_valid / req_stall
// rsp      out  digest_word[63:0] word_index[2:0] last    rsp_valid / rsp_stall
//
// A 16-word block takes 16 queue pops, 80 rounds and a fold into the chain;
// the single round unit bounds the hashing rate.
// A last item adds 2 to 18 padding words, then 8 digest words.
// Reset is synchronous; the queue lets the front end take items during rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_hasher_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_valid_bytes,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_digest_last
);
   import sha512_pkg::*;

   `include "sha512_hasher_unit_assert.svh"

   queue_item_type                    push_item, pop_item;
   logic                              push_valid, queue_full, queue_empty, queue_pop;
   logic [$clog2(QUEUE_DEPTH+1)-1:0]  queue_level;

   sha512_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last_word   (req_last_word),
      .push_valid      (push_valid),
      .push_item       (push_item),
      .queue_full      (queue_full)
   );

   sha512_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_item  (pop_item),
      .empty     (queue_empty),
      .level     (queue_level)
   );

   sha512_core u_core (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .queue_item      (pop_item),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_last (rsp_digest_last)
   );

   `SHA_ASSERT_SAME(a_no_overflow, clock, reset, push_valid, !queue_full, "push into full queue")
   `SHA_ASSERT_SAME(a_level_range, clock, reset, 1'b1,
      queue_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue level out of range")
   `SHA_ASSERT_NEXT(a_digest_done, clock, reset, rsp_valid && !rsp_stall && rsp_digest_last,
      !rsp_valid, "digest continues past last word")
   `SHA_ASSERT_SAME(a_no_pop_in_digest, clock, reset, rsp_valid, !queue_pop,
      "queue popped during digest output")

endmodule

`default_nettype wire
